[hdl/sml_pkg.sv]
`timescale 1ns / 1ps

package sml_pkg;

  localparam int LENGTH_WIDTH_DEFAULT = 32;

  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // candidate key bits
  localparam logic [2:0] CAND_CL  = 3'b001;
  localparam logic [2:0] CAND_L   = 3'b010;
  localparam logic [2:0] CAND_TE  = 3'b100;
  localparam logic [2:0] CAND_ALL = 3'b111;

  localparam logic [4:0] KEY_CL_LEN = 5'd14;
  localparam logic [4:0] KEY_L_LEN  = 5'd1;
  localparam logic [4:0] KEY_TE_LEN = 5'd17;
  localparam logic [4:0] KEY_POS_MAX = 5'd31;

  typedef enum logic [2:0] {
    ST_BODY         = 3'd0,
    ST_NO_LENGTH    = 3'd1,
    ST_NO_SEPARATOR = 3'd2,
    ST_ENCODING     = 3'd3,
    ST_BAD_LENGTH   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    VP_KEY   = 2'd0,
    VP_GAP   = 2'd1,
    VP_VALUE = 2'd2
  } value_phase_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic encoding_seen;
    logic length_nonempty;
    logic length_error;
    logic digits_seen;
  } scan_flags_t;

  function automatic logic [7:0] cl_key_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:  ch = "c";
      5'd1:  ch = "o";
      5'd2:  ch = "n";
      5'd3:  ch = "t";
      5'd4:  ch = "e";
      5'd5:  ch = "n";
      5'd6:  ch = "t";
      5'd7:  ch = "-";
      5'd8:  ch = "l";
      5'd9:  ch = "e";
      5'd10: ch = "n";
      5'd11: ch = "g";
      5'd12: ch = "t";
      5'd13: ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] te_key_char(input logic [4:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:  ch = "t";
      5'd1:  ch = "r";
      5'd2:  ch = "a";
      5'd3:  ch = "n";
      5'd4:  ch = "s";
      5'd5:  ch = "f";
      5'd6:  ch = "e";
      5'd7:  ch = "r";
      5'd8:  ch = "-";
      5'd9:  ch = "e";
      5'd10: ch = "n";
      5'd11: ch = "c";
      5'd12: ch = "o";
      5'd13: ch = "d";
      5'd14: ch = "i";
      5'd15: ch = "n";
      5'd16: ch = "g";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == CH_CR) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

[hdl/sml_scan.sv]
`timescale 1ns / 1ps

module sml_scan import sml_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    rearm,
  input  logic [7:0]              data,
  output scan_flags_t             flags,
  output logic [LENGTH_WIDTH-1:0] length_value
);

  typedef struct packed {
    logic [1:0]              line_cnt;
    logic [4:0]              key_pos;
    logic [2:0]              cand;
    value_phase_t            vphase;
    logic                    nonempty;
    parse_phase_t            pphase;
    logic [LENGTH_WIDTH-1:0] value;
    logic                    error;
    logic                    enc;
  } line_state_t;

  localparam logic [LENGTH_WIDTH+3:0] LimitExt = {4'b0, {LENGTH_WIDTH{1'b1}}};

  localparam line_state_t LineReset = '{
    line_cnt: 2'd0,
    key_pos:  5'd0,
    cand:     CAND_ALL,
    vphase:   VP_KEY,
    nonempty: 1'b0,
    pphase:   PH_SKIP,
    value:    '0,
    error:    1'b0,
    enc:      1'b0
  };

  function automatic line_state_t value_char(input line_state_t s, input logic [7:0] c);
    line_state_t             r;
    logic [LENGTH_WIDTH+3:0] prod;
    logic [LENGTH_WIDTH+3:0] vext;
    logic [LENGTH_WIDTH+3:0] dext;
    r          = s;
    vext       = {4'b0, s.value};
    dext       = (LENGTH_WIDTH+4)'(c[3:0]);
    prod       = (vext << 3) + (vext << 1) + dext;
    r.nonempty = 1'b1;
    case (s.pphase)
      PH_SKIP: begin
        if (!is_space(c)) begin
          if (is_digit(c)) begin
            r.value  = LENGTH_WIDTH'(c[3:0]);
            r.pphase = PH_DIGITS;
          end else begin
            r.error  = 1'b1;
            r.pphase = PH_DONE;
          end
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          if (prod > LimitExt) begin
            r.error  = 1'b1;
            r.pphase = PH_DONE;
          end else begin
            r.value = prod[LENGTH_WIDTH-1:0];
          end
        end else begin
          r.pphase = PH_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic line_state_t commit(input line_state_t s, input logic [7:0] c);
    line_state_t r;
    logic [7:0]  lc;
    logic [2:0]  m;
    r  = s;
    lc = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    m  = '0;
    if (s.line_cnt != 2'd3) r.line_cnt = s.line_cnt + 2'd1;
    case (s.vphase)
      VP_KEY: begin
        if (c == CH_COLON) begin
          if (s.cand[0] && s.key_pos == KEY_CL_LEN) m = m | CAND_CL;
          if (s.cand[1] && s.key_pos == KEY_L_LEN)  m = m | CAND_L;
          if (s.cand[2] && s.key_pos == KEY_TE_LEN) m = m | CAND_TE;
          r.cand   = m;
          r.vphase = VP_GAP;
          if ((m & (CAND_CL | CAND_L)) != 3'b000) begin
            r.nonempty = 1'b0;
            r.pphase   = PH_SKIP;
            r.value    = '0;
            r.error    = 1'b0;
          end
          if (m[2]) r.enc = 1'b1;
        end else begin
          if (s.cand[0] && !(s.key_pos < KEY_CL_LEN && cl_key_char(s.key_pos) == lc))
            r.cand[0] = 1'b0;
          if (s.cand[1] && !(s.key_pos == 5'd0 && lc == "l"))
            r.cand[1] = 1'b0;
          if (s.cand[2] && !(s.key_pos < KEY_TE_LEN && te_key_char(s.key_pos) == lc))
            r.cand[2] = 1'b0;
          if (s.key_pos != KEY_POS_MAX) r.key_pos = s.key_pos + 5'd1;
        end
      end
      VP_GAP: r.vphase = VP_VALUE;
      default: begin
        if ((s.cand & (CAND_CL | CAND_L)) != 3'b000) r = value_char(r, c);
      end
    endcase
    return r;
  endfunction

  line_state_t cur, cur_next, after_cr;
  logic        past_first, past_first_next;
  logic        stopped, stopped_next;
  logic        pending_cr, pending_cr_next;

  always_comb begin
    cur_next        = cur;
    past_first_next = past_first;
    stopped_next    = stopped;
    pending_cr_next = pending_cr;
    after_cr        = pending_cr ? commit(cur, CH_CR) : cur;
    if (step) begin
      if (!past_first) begin
        if (data == CH_LF) past_first_next = 1'b1;
      end else if (!stopped) begin
        if (data == CH_LF) begin
          if (cur.line_cnt == 2'd0) stopped_next = 1'b1;
          cur_next.line_cnt = 2'd0;
          cur_next.key_pos  = 5'd0;
          cur_next.cand     = CAND_ALL;
          cur_next.vphase   = VP_KEY;
          pending_cr_next   = 1'b0;
        end else if (data == CH_CR) begin
          cur_next        = after_cr;
          pending_cr_next = 1'b1;
        end else begin
          cur_next        = commit(after_cr, data);
          pending_cr_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      cur        <= LineReset;
      past_first <= 1'b0;
      stopped    <= 1'b0;
      pending_cr <= 1'b0;
    end else begin
      cur        <= cur_next;
      past_first <= past_first_next;
      stopped    <= stopped_next;
      pending_cr <= pending_cr_next;
    end
  end

  assign flags.encoding_seen   = cur.enc;
  assign flags.length_nonempty = cur.nonempty;
  assign flags.length_error    = cur.error;
  assign flags.digits_seen     = (cur.pphase != PH_SKIP);
  assign length_value          = cur.value;

endmodule

[hdl/sml_frame.sv]
`timescale 1ns / 1ps

module sml_frame import sml_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data,
  input  logic                    last,
  input  scan_flags_t             flags,
  input  logic [LENGTH_WIDTH-1:0] length_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [31:0]             total_length,
  output logic [2:0]              status,
  output logic                    result_given,
  output logic                    emit
);

  localparam int SumW = ((LENGTH_WIDTH > 33) ? LENGTH_WIDTH : 33) + 1;
  localparam logic [SumW-1:0] PosMaxExt = SumW'(POS_MAX);

  logic [1:0]      sep, sep_next, sep_adv;
  logic [31:0]     byte_pos, byte_pos_next;
  logic            found;
  logic            out_valid_next;
  logic            result_given_next;
  logic [31:0]     total_next;
  logic [2:0]      status_next;
  logic [SumW-1:0] hdr, len_ext, sum;
  logic [31:0]     res_total;
  status_t         res_status;

  always_comb begin
    case (data)
      CH_CR:   sep_adv = (sep == 2'd2) ? 2'd3 : 2'd1;
      CH_LF:   sep_adv = (sep == 2'd1) ? 2'd2 : 2'd0;
      default: sep_adv = 2'd0;
    endcase
    found = (data == CH_LF) && (sep == 2'd3);
    // this byte gives a result beat
    emit  = !result_given && (found || last);
  end

  always_comb begin
    hdr        = SumW'(byte_pos) + SumW'(1);
    len_ext    = SumW'(length_value);
    sum        = hdr + len_ext;
    res_total  = '0;
    res_status = ST_BODY;
    if (flags.encoding_seen) begin
      res_status = ST_ENCODING;
    end else if (!flags.length_nonempty) begin
      if (hdr > PosMaxExt) begin
        res_status = ST_BAD_LENGTH;
      end else begin
        res_status = ST_NO_LENGTH;
        res_total  = hdr[31:0];
      end
    end else if (flags.length_error || !flags.digits_seen || len_ext > PosMaxExt ||
                 sum > PosMaxExt) begin
      res_status = ST_BAD_LENGTH;
    end else begin
      res_total = sum[31:0];
    end
  end

  always_comb begin
    sep_next          = sep;
    byte_pos_next     = byte_pos;
    result_given_next = result_given;
    out_valid_next    = out_valid && !out_ready;
    total_next        = total_length;
    status_next       = status;
    if (step) begin
      if (!result_given) begin
        sep_next = sep_adv;
        if (byte_pos != POS_MAX) byte_pos_next = byte_pos + 32'd1;
        if (found) begin
          out_valid_next    = 1'b1;
          total_next        = res_total;
          status_next       = res_status;
          result_given_next = 1'b1;
        end
      end
      if (last) begin
        if (!found && !result_given) begin
          out_valid_next = 1'b1;
          total_next     = '0;
          status_next    = ST_NO_SEPARATOR;
        end
        sep_next          = 2'd0;
        byte_pos_next     = '0;
        result_given_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep          <= 2'd0;
      byte_pos     <= '0;
      result_given <= 1'b0;
      out_valid    <= 1'b0;
      total_length <= '0;
      status       <= ST_BODY;
    end else begin
      sep          <= sep_next;
      byte_pos     <= byte_pos_next;
      result_given <= result_given_next;
      out_valid    <= out_valid_next;
      total_length <= total_next;
      status       <= status_next;
    end
  end

endmodule

[hdl/sip_message_length_framer.sv]
`timescale 1ns / 1ps

// Scans a received buffer one byte per beat for the first CRLFCRLF and returns one beat
// per buffer: the header length plus the Content-Length (or compact "l") value, with a
// status code; transfer-encoding, a missing separator and a bad length give error codes
// with a zero length. Throughput is one byte per cycle unless a result beat holds input
// back: a byte is taken into an input register and scanned from there straight into the
// result register, so a result is registered from the beat that completes the separator
// (or carries last_byte). While a result waits, bytes that give no result keep flowing; a
// byte that would give the next result waits in the input register and holds back input
// until the waiting result is taken. The block rearms after each byte flagged last_byte.
module sip_message_length_framer import sml_pkg::*; #(
  parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] total_length,
  output logic [2:0]  status
);

  logic                    held;
  logic [7:0]              data_q;
  logic                    last_q;
  logic                    advance;
  logic                    emit;
  logic                    result_given;
  scan_flags_t             flags;
  logic [LENGTH_WIDTH-1:0] length_value;

  assign advance  = held && (!out_valid || out_ready || !emit);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_q <= data_byte;
      last_q <= last_byte;
    end
  end

  sml_scan #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .step         (advance && !result_given),
    .rearm        (advance && last_q),
    .data         (data_q),
    .flags        (flags),
    .length_value (length_value)
  );

  sml_frame #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data         (data_q),
    .last         (last_q),
    .flags        (flags),
    .length_value (length_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .total_length (total_length),
    .status       (status),
    .result_given (result_given),
    .emit         (emit)
  );

`ifndef SYNTH
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_SEPARATOR || status == ST_ENCODING ||
                  status == ST_BAD_LENGTH) |-> total_length == 32'd0)
    else $error("error status with non-zero length");

  a_min_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BODY || status == ST_NO_LENGTH) |-> total_length >= 32'd4)
    else $error("length shorter than the separator");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_LENGTH)
    else $error("status code out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_length) && $stable(status))
    else $error("stalled result beat changed");
`endif

endmodule
